// File: rtl/core/gwf_pkg.sv
// Shared types, codes and helper functions for the grid wall-follow navigator.
`default_nettype none

package gwf_pkg;

    localparam int ROWS_DEFAULT = 8;
    localparam int COLS_DEFAULT = 8;
    localparam int COORD_CAP    = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] CFG_OBSTACLE_CM = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VISIT_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_FIRST = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_LAST  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_ROWS    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_COLS    = 3'd5;

    localparam logic [1:0] CMD_DECIDE = 2'd0;
    localparam logic [1:0] CMD_RANGE  = 2'd1;
    localparam logic [1:0] CMD_CELL   = 2'd2;
    localparam logic [1:0] CMD_POSE   = 2'd3;

    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_OBST = 2'd1;
    localparam logic [1:0] KIND_BOX  = 2'd2;

    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    localparam logic [1:0] TURN_NONE  = 2'd0;
    localparam logic [1:0] TURN_RIGHT = 2'd1;
    localparam logic [1:0] TURN_ABOUT = 2'd2;
    localparam logic [1:0] TURN_LEFT  = 2'd3;

    localparam logic [1:0] VISIT_SAT = 2'd3;

    localparam logic [8:0] RST_OBSTACLE_CM = 9'd18;
    localparam logic [1:0] RST_VISIT_LIMIT = 2'd2;
    localparam logic [2:0] RST_INNER_FIRST = 3'd1;
    localparam logic [2:0] RST_INNER_LAST  = 3'd4;
    localparam logic [3:0] RST_MAP_ROWS    = 4'd6;
    localparam logic [3:0] RST_MAP_COLS    = 4'd6;

    typedef struct packed {
        logic [1:0] cmd;
        logic       inner_only;
        logic       prefer_left;
        logic [8:0] range_cm;
        logic [2:0] row;
        logic [2:0] col;
        logic [1:0] cell_kind;
        logic [1:0] heading;
    } in_item_t;

    typedef struct packed {
        logic [1:0] new_heading;
        logic [1:0] turn;
        logic       moved;
        logic [2:0] pos_row;
        logic [2:0] pos_col;
        logic       marked_blocked;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [8:0] obstacle_cm;
        logic [1:0] visit_limit;
        logic [2:0] inner_first;
        logic [2:0] inner_last;
        logic [3:0] rows_used;
        logic [3:0] cols_used;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_DECIDE,
        OP_RANGE,
        OP_CELL,
        OP_POSE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       inner_only;
        logic       prefer_left;
        logic       near;
        logic       tgt_ok;
        logic       kind_ok;
        logic [2:0] row;
        logic [2:0] col;
        logic [1:0] cell_kind;
        logic [1:0] heading;
    } work_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD1,
        BK_RD2,
        BK_DEC,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] r;
        logic [3:0] c;
    } nbr_t;

    function automatic logic in_map(input logic [3:0] r, input logic [3:0] c,
                                    input cfg_t cfg);
        return (r < cfg.rows_used) && (c < cfg.cols_used);
    endfunction

    function automatic nbr_t neighbor(input logic [2:0] row, input logic [2:0] col,
                                      input logic [1:0] dir, input cfg_t cfg);
        nbr_t n;
        logic geom;
        n.r  = {1'b0, row};
        n.c  = {1'b0, col};
        geom = 1'b1;
        case (dir)
            HEAD_NORTH:
            begin
                geom = (row != 3'd0);
                n.r  = {1'b0, row} - 4'd1;
            end
            HEAD_EAST:  n.c = {1'b0, col} + 4'd1;
            HEAD_SOUTH: n.r = {1'b0, row} + 4'd1;
            HEAD_WEST:
            begin
                geom = (col != 3'd0);
                n.c  = {1'b0, col} - 4'd1;
            end
            default: geom = 1'b0;
        endcase
        n.ok = geom && in_map(n.r, n.c, cfg);
        return n;
    endfunction

    function automatic logic in_ring(input logic [3:0] r, input logic [3:0] c,
                                     input cfg_t cfg);
        return (r >= {1'b0, cfg.inner_first}) && (r <= {1'b0, cfg.inner_last}) &&
               (c >= {1'b0, cfg.inner_first}) && (c <= {1'b0, cfg.inner_last});
    endfunction

    function automatic logic is_blocked(input logic [1:0] kind);
        return (kind == KIND_OBST) || (kind == KIND_BOX);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/grid_wall_follow_navigator_core.sv
// Top level of the grid wall-follow navigator: front end, item queue, back end.
// The back end takes one queued item at a time. A decide reads the map in BK_IDLE, BK_RD1 and
// BK_RD2 (three neighbor reads share the map read port) and then resolves in BK_DEC; a range
// report, cell write or pose write goes from BK_IDLE to BK_EXEC (back-end sequencer).
// Reset: map reads as all free and visit counts as zero at once (per-entry valid bits);
// pose is row 0, column 0, heading north. No clearing pass.
`default_nettype none

module grid_wall_follow_navigator_core
    import gwf_pkg::*;
#(
    parameter int MAX_ROWS = ROWS_DEFAULT,
    parameter int MAX_COLS = COLS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_item
);

    cfg_t  cfg;
    logic  push_valid, push_ready;
    work_t push_item;
    logic  pop_valid, pop_ready;
    work_t pop_item;

    gwf_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .cfg       (cfg)
    );

    gwf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item)
    );

    gwf_back #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_item (pop_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

// File: rtl/core/gwf_front.sv
// Front end: configuration registers, item intake and command classification.
`default_nettype none

module gwf_front
    import gwf_pkg::*;
#(
    parameter int MAX_ROWS = ROWS_DEFAULT,
    parameter int MAX_COLS = COLS_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_item,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output work_t                       push_item,
    output cfg_t                        cfg
);

    localparam int ROW_CAP = (MAX_ROWS < COORD_CAP) ? MAX_ROWS : COORD_CAP;
    localparam int COL_CAP = (MAX_COLS < COORD_CAP) ? MAX_COLS : COORD_CAP;
    localparam logic [3:0] ROW_CAP_V = 4'(ROW_CAP);
    localparam logic [3:0] COL_CAP_V = 4'(COL_CAP);

    logic [8:0] obstacle_cm_reg;
    logic [1:0] visit_limit_reg;
    logic [2:0] inner_first_reg;
    logic [2:0] inner_last_reg;
    logic [3:0] map_rows_reg;
    logic [3:0] map_cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_cm_reg <= RST_OBSTACLE_CM;
            visit_limit_reg <= RST_VISIT_LIMIT;
            inner_first_reg <= RST_INNER_FIRST;
            inner_last_reg  <= RST_INNER_LAST;
            map_rows_reg    <= RST_MAP_ROWS;
            map_cols_reg    <= RST_MAP_COLS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OBSTACLE_CM: obstacle_cm_reg <= cfg_wdata[8:0];
                CFG_VISIT_LIMIT: visit_limit_reg <= cfg_wdata[1:0];
                CFG_INNER_FIRST: inner_first_reg <= cfg_wdata[2:0];
                CFG_INNER_LAST:  inner_last_reg  <= cfg_wdata[2:0];
                CFG_MAP_ROWS:    map_rows_reg    <= cfg_wdata[3:0];
                CFG_MAP_COLS:    map_cols_reg    <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.obstacle_cm = obstacle_cm_reg;
        cfg.visit_limit = visit_limit_reg;
        cfg.inner_first = inner_first_reg;
        cfg.inner_last  = inner_last_reg;
        cfg.rows_used   = (map_rows_reg < ROW_CAP_V) ? map_rows_reg : ROW_CAP_V;
        cfg.cols_used   = (map_cols_reg < COL_CAP_V) ? map_cols_reg : COL_CAP_V;
    end

    always_comb
    begin
        case (in_item.cmd)
            CMD_DECIDE: push_item.op = OP_DECIDE;
            CMD_RANGE:  push_item.op = OP_RANGE;
            CMD_CELL:   push_item.op = OP_CELL;
            CMD_POSE:   push_item.op = OP_POSE;
            default:    push_item.op = OP_DECIDE;
        endcase
        push_item.inner_only  = in_item.inner_only;
        push_item.prefer_left = in_item.prefer_left;
        push_item.near        = (in_item.range_cm != 9'd0) &&
                                (in_item.range_cm < obstacle_cm_reg);
        push_item.tgt_ok      = in_map({1'b0, in_item.row}, {1'b0, in_item.col}, cfg);
        push_item.kind_ok     = (in_item.cell_kind <= KIND_BOX);
        push_item.row         = in_item.row;
        push_item.col         = in_item.col;
        push_item.cell_kind   = in_item.cell_kind;
        push_item.heading     = in_item.heading;
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

`default_nettype wire

// File: rtl/core/gwf_queue.sv
// Short FIFO of classified items between the front and back ends.
`default_nettype none

module gwf_queue
    import gwf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire work_t push_item,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output work_t      pop_item
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam logic [QW:0] FULL_CNT = (QW + 1)'(QUEUE_DEPTH);

    work_t          slot_mem [QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QW:0]    count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/gwf_back.sv
// Back end: map and visit memories, robot pose, decision sequencer, result register.
`default_nettype none

module gwf_back
    import gwf_pkg::*;
#(
    parameter int MAX_ROWS = ROWS_DEFAULT,
    parameter int MAX_COLS = COLS_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire work_t pop_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output out_item_t  out_item
);

    localparam int ROW_CAP = (MAX_ROWS < COORD_CAP) ? MAX_ROWS : COORD_CAP;
    localparam int COL_CAP = (MAX_COLS < COORD_CAP) ? MAX_COLS : COORD_CAP;
    localparam int RB      = $clog2(ROW_CAP);
    localparam int CB      = $clog2(COL_CAP);
    localparam int AW      = RB + CB;
    localparam int DEPTH   = 1 << AW;

    function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
        return {r[RB-1:0], c[CB-1:0]};
    endfunction

    back_state_t state_reg, state_next;
    work_t       work_reg, work_next;
    logic        cand_rt_reg, cand_rt_next;
    logic        cand_fw_reg, cand_fw_next;
    logic [2:0]  robot_row_reg, robot_row_next;
    logic [2:0]  robot_col_reg, robot_col_next;
    logic [1:0]  heading_reg, heading_next;
    logic        out_vld_reg, out_vld_next;
    out_item_t   out_item_reg, out_item_next;

    logic [1:0]       cell_mem [DEPTH];
    logic [DEPTH-1:0] cell_vld_reg;
    logic [1:0]       cell_rdata_reg;
    logic             cell_rvld_reg;
    logic             cell_rd_en, cell_we;
    logic [AW-1:0]    cell_rd_addr, cell_wr_addr;
    logic [1:0]       cell_wdata;

    logic [7:0]       visit_mem [DEPTH];
    logic [DEPTH-1:0] visit_vld_reg;
    logic [7:0]       visit_rdata_reg;
    logic             visit_rvld_reg;
    logic             visit_rd_en, visit_we;
    logic [AW-1:0]    visit_addr;
    logic [7:0]       visit_wdata;

    logic [1:0] dir_rt, dir_lt, dir_back;
    nbr_t       nb_rt, nb_fw, nb_lt;
    logic       robot_ok, out_free, load;
    logic [1:0] kind_rd;
    logic [7:0] vrow;
    logic       cand_rt_now, cand_fw_now, cand_lt_now;
    logic       c_first, c_third;
    logic [1:0] d_first, d_third, dec_dir, cnt_dec;
    logic [1:0] res_turn;
    logic       res_moved, res_marked, res_status;

    function automatic logic cand(input nbr_t n, input logic [1:0] kind,
                                  input logic [1:0] cnt, input logic inner,
                                  input logic here_ok, input cfg_t c);
        logic pass;
        pass = inner ? in_ring(n.r, n.c, c) : (!here_ok || (cnt < c.visit_limit));
        return n.ok && !is_blocked(kind) && pass;
    endfunction

    assign dir_rt   = heading_reg + 2'd1;
    assign dir_lt   = heading_reg + 2'd3;
    assign dir_back = heading_reg + 2'd2;
    assign nb_rt    = neighbor(robot_row_reg, robot_col_reg, dir_rt, cfg);
    assign nb_fw    = neighbor(robot_row_reg, robot_col_reg, heading_reg, cfg);
    assign nb_lt    = neighbor(robot_row_reg, robot_col_reg, dir_lt, cfg);
    assign robot_ok = in_map({1'b0, robot_row_reg}, {1'b0, robot_col_reg}, cfg);
    assign kind_rd  = cell_rvld_reg ? cell_rdata_reg : KIND_FREE;
    assign vrow     = visit_rvld_reg ? visit_rdata_reg : 8'd0;
    assign out_free = !out_vld_reg || out_ready;
    assign visit_addr = cell_addr({1'b0, robot_row_reg}, {1'b0, robot_col_reg});

    assign cand_rt_now = cand(nb_rt, kind_rd, vrow[{dir_rt, 1'b0} +: 2],
                              work_reg.inner_only, robot_ok, cfg);
    assign cand_fw_now = cand(nb_fw, kind_rd, vrow[{heading_reg, 1'b0} +: 2],
                              work_reg.inner_only, robot_ok, cfg);
    assign cand_lt_now = cand(nb_lt, kind_rd, vrow[{dir_lt, 1'b0} +: 2],
                              work_reg.inner_only, robot_ok, cfg);

    always_comb
    begin
        c_first = work_reg.prefer_left ? cand_lt_now : cand_rt_reg;
        c_third = work_reg.prefer_left ? cand_rt_reg : cand_lt_now;
        d_first = work_reg.prefer_left ? dir_lt : dir_rt;
        d_third = work_reg.prefer_left ? dir_rt : dir_lt;
        if (c_first)
        begin
            dec_dir = d_first;
        end
        else if (cand_fw_reg)
        begin
            dec_dir = heading_reg;
        end
        else if (c_third)
        begin
            dec_dir = d_third;
        end
        else
        begin
            dec_dir = dir_back;
        end
        cnt_dec     = vrow[{dec_dir, 1'b0} +: 2];
        visit_wdata = vrow;
        visit_wdata[{dec_dir, 1'b0} +: 2] = cnt_dec + 2'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        cand_rt_next   = cand_rt_reg;
        cand_fw_next   = cand_fw_reg;
        robot_row_next = robot_row_reg;
        robot_col_next = robot_col_reg;
        heading_next   = heading_reg;
        pop_ready      = 1'b0;
        load           = 1'b0;
        res_turn       = TURN_NONE;
        res_moved      = 1'b0;
        res_marked     = 1'b0;
        res_status     = 1'b0;
        cell_rd_en     = 1'b0;
        cell_rd_addr   = cell_addr(nb_rt.r, nb_rt.c);
        cell_we        = 1'b0;
        cell_wr_addr   = cell_addr(nb_fw.r, nb_fw.c);
        cell_wdata     = KIND_OBST;
        visit_rd_en    = 1'b0;
        visit_we       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    work_next = pop_item;
                    if (pop_item.op == OP_DECIDE)
                    begin
                        cell_rd_en  = 1'b1;
                        visit_rd_en = 1'b1;
                        state_next  = BK_RD1;
                    end
                    else
                    begin
                        state_next = BK_EXEC;
                    end
                end
            end
            BK_RD1:
            begin
                cand_rt_next = cand_rt_now;
                cell_rd_en   = 1'b1;
                cell_rd_addr = cell_addr(nb_fw.r, nb_fw.c);
                state_next   = BK_RD2;
            end
            BK_RD2:
            begin
                cand_fw_next = cand_fw_now;
                cell_rd_en   = 1'b1;
                cell_rd_addr = cell_addr(nb_lt.r, nb_lt.c);
                state_next   = BK_DEC;
            end
            BK_DEC:
            begin
                if (out_free)
                begin
                    load         = 1'b1;
                    visit_we     = robot_ok && (cnt_dec < VISIT_SAT);
                    heading_next = dec_dir;
                    res_turn     = 2'(dec_dir - heading_reg);
                    state_next   = BK_IDLE;
                end
            end
            BK_EXEC:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                    case (work_reg.op)
                        OP_RANGE:
                        begin
                            if (work_reg.near)
                            begin
                                cell_we      = nb_fw.ok;
                                res_marked   = nb_fw.ok;
                                heading_next = dir_back;
                                res_turn     = TURN_ABOUT;
                            end
                            else if (nb_fw.ok)
                            begin
                                robot_row_next = nb_fw.r[2:0];
                                robot_col_next = nb_fw.c[2:0];
                                res_moved      = 1'b1;
                            end
                            else
                            begin
                                res_status = 1'b1;
                            end
                        end
                        OP_CELL:
                        begin
                            cell_wr_addr = cell_addr({1'b0, work_reg.row}, {1'b0, work_reg.col});
                            cell_wdata   = work_reg.cell_kind;
                            cell_we      = work_reg.tgt_ok && work_reg.kind_ok;
                            res_status   = !work_reg.tgt_ok;
                        end
                        OP_POSE:
                        begin
                            res_status = !work_reg.tgt_ok;
                            if (work_reg.tgt_ok)
                            begin
                                robot_row_next = work_reg.row;
                                robot_col_next = work_reg.col;
                                heading_next   = work_reg.heading;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default: state_next = BK_IDLE;
        endcase

        out_vld_next  = load ? 1'b1 : (out_vld_reg && !out_ready);
        out_item_next = out_item_reg;
        if (load)
        begin
            out_item_next.new_heading    = heading_next;
            out_item_next.turn           = res_turn;
            out_item_next.moved          = res_moved;
            out_item_next.pos_row        = robot_row_next;
            out_item_next.pos_col        = robot_col_next;
            out_item_next.marked_blocked = res_marked;
            out_item_next.status         = res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            robot_row_reg <= 3'd0;
            robot_col_reg <= 3'd0;
            heading_reg   <= HEAD_NORTH;
            out_vld_reg   <= 1'b0;
            cell_vld_reg  <= '0;
            visit_vld_reg <= '0;
            cell_rvld_reg <= 1'b0;
            visit_rvld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            robot_row_reg <= robot_row_next;
            robot_col_reg <= robot_col_next;
            heading_reg   <= heading_next;
            out_vld_reg   <= out_vld_next;
            if (cell_we)
            begin
                cell_vld_reg[cell_wr_addr] <= 1'b1;
            end
            if (visit_we)
            begin
                visit_vld_reg[visit_addr] <= 1'b1;
            end
            if (cell_rd_en)
            begin
                cell_rvld_reg <= cell_vld_reg[cell_rd_addr];
            end
            if (visit_rd_en)
            begin
                visit_rvld_reg <= visit_vld_reg[visit_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        cand_rt_reg  <= cand_rt_next;
        cand_fw_reg  <= cand_fw_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wr_addr] <= cell_wdata;
        end
        if (cell_rd_en)
        begin
            cell_rdata_reg <= cell_mem[cell_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (visit_we)
        begin
            visit_mem[visit_addr] <= visit_wdata;
        end
        if (visit_rd_en)
        begin
            visit_rdata_reg <= visit_mem[visit_addr];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// File: rtl/core/gwf_checker.sv
// Port-level checker for the navigator core and its bind.
`default_nettype none

module gwf_checker
    import gwf_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_ready,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_item
);

    logic [3:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 4'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // every result belongs to an accepted item, and at most four items are in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 4'd0)
        else $error("result with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("too many items in flight");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_move_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.moved |->
            out_item.turn == TURN_NONE && !out_item.status && !out_item.marked_blocked)
        else $error("advance reported with turn, mark or refusal");

    a_mark_about: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.marked_blocked || out_item.status) |->
            (out_item.marked_blocked ? out_item.turn == TURN_ABOUT
                                     : out_item.turn == TURN_NONE))
        else $error("mark or refusal with wrong turn");

endmodule

bind grid_wall_follow_navigator_core gwf_checker u_gwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
);

`default_nettype wire
